FILE: hw/rtl/tsam_pkg.sv
// tsam_pkg: widths, channel codes, register indexes and divider request types
// shared by the touch averaging block, its divider and its checker
// depends on nothing
`default_nettype none

package tsam_pkg;

  // converter reading and mapped coordinate width
  localparam int VAL_W  = 12;
  // divider dividend width, wide enough for a 12x12 product
  localparam int DIV_W  = 24;
  // width of the divider step count, holds DIV_W
  localparam int STEP_W = 5;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  // conversion kind carried in tuser
  localparam logic [IN_TUSER_W-1:0] CH_PRESSURE = 2'd0;
  localparam logic [IN_TUSER_W-1:0] CH_X        = 2'd1;
  localparam logic [IN_TUSER_W-1:0] CH_Y        = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IRQ_ENABLE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_X_RAW_MIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_X_RAW_MAX     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_Y_RAW_MIN     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_Y_RAW_MAX     = 3'd6;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [VAL_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tsam_div.sv
// tsam_div: restoring divider, one quotient bit per cycle
// dividend is left aligned, steps gives the quotient length
// depends on tsam_pkg
`default_nettype none

module tsam_div
  import tsam_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]  dvd_q;
  logic [DIV_W-1:0]  quo_q;
  logic [VAL_W-1:0]  dsr_q;
  logic [VAL_W-1:0]  rem_q;

  logic [VAL_W:0]   trial;
  logic             fits;
  logic [VAL_W-1:0] rem_d;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  // remainder stays below the divisor, so it fits back in VAL_W bits
  assign rem_d = fits ? VAL_W'(trial - {1'b0, dsr_q}) : trial[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[VAL_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/touch_sample_average_and_map.sv
// Touch sample averaging and screen mapping.
// Input stream: one converter response per request. tuser holds the kind
// (pressure, X or Y), tdata the 16-bit frame and the pen IRQ level. A
// pressure request starts a scan; X and Y readings (frame bits 14..3) are
// summed with saturation. The SAMPLES-th Y request ends the scan and later
// yields one result request on the output stream: touch flag, mapped X/Y
// pixels, pressure and the two truncated raw averages.
// Pressure, X and plain Y requests never stall. The last Y request keeps
// the input not ready while the two averages come from a constant reciprocal
// multiply, one axis a cycle, then, when touched, while one shared restoring
// divider (one bit a cycle) runs two mappings of 24 steps each behind a clamp
// and a 12x12 multiply: the result is loaded and the input is ready again
// once the output register is free. The result sits in an output register,
// so the next scan's requests are taken while it waits; a scan end finds
// the divider path stalled only if the previous result is still not taken
// when its own result is ready. Configuration is a plain write port,
// written by the user while the block is idle; the block does not enforce it.
// Reset clears the scan state and the touch history and loads the default
// calibration (320x480 screen, X 220..3850, Y 260..3820, IRQ unused).
// depends on tsam_pkg and tsam_div
`default_nettype none

module touch_sample_average_and_map
  import tsam_pkg::*;
#(
  parameter int SAMPLES       = 4,
  parameter int PRESS_LEVEL   = 20,
  parameter int RELEASE_LEVEL = 8
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // [15:0] frame, [16] irq_level, [23:17] zero
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] channel
  input  wire [IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // [0] touched, [12:1] x_pos, [24:13] y_pos, [36:25] pressure,
  // [48:37] raw_x_avg, [60:49] raw_y_avg, [63:61] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire                    cfg_we_i,
  input  wire [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int ACC_W = $clog2(SAMPLES * 4095 + 1);
  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [ACC_W:0] ACC_LIMIT = (ACC_W + 1)'(SAMPLES * 4095);
  // rounded-up reciprocal of SAMPLES, exact over the accumulator range
  localparam int REC_SH = ACC_W + $clog2(SAMPLES);
  localparam int REC_W  = ACC_W + 1;
  localparam logic [REC_W-1:0] RECIP = REC_W'(((1 << REC_SH) + SAMPLES - 1) / SAMPLES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_RUN,
    ST_CLAMP,
    ST_MULT,
    ST_MAP_RUN,
    ST_EMIT
  } state_e;

  // configuration
  logic             irq_en_q;
  logic [VAL_W-1:0] scr_w_q, scr_h_q;
  logic [VAL_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q <= 1'b0;
      scr_w_q  <= 12'd320;
      scr_h_q  <= 12'd480;
      x_min_q  <= 12'd220;
      x_max_q  <= 12'd3850;
      y_min_q  <= 12'd260;
      y_max_q  <= 12'd3820;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_IRQ_ENABLE:    irq_en_q <= cfg_data_i[0];
        REG_SCREEN_WIDTH:  scr_w_q  <= cfg_data_i;
        REG_SCREEN_HEIGHT: scr_h_q  <= cfg_data_i;
        REG_X_RAW_MIN:     x_min_q  <= cfg_data_i;
        REG_X_RAW_MAX:     x_max_q  <= cfg_data_i;
        REG_Y_RAW_MIN:     y_min_q  <= cfg_data_i;
        REG_Y_RAW_MAX:     y_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scan state
  state_e           state_q;
  logic [VAL_W-1:0] press_q;
  logic [ACC_W-1:0] x_acc_q, y_acc_q;
  logic [CNT_W-1:0] cnt_q;
  logic             was_touched_q;
  logic             touch_q;
  logic             axis_q;
  logic [VAL_W-1:0] avg_x_q, avg_y_q;
  logic [VAL_W-1:0] pos_x_q, pos_y_q;
  logic [VAL_W-1:0] diff_q, span_q, scrm1_q;
  logic             zero_q;
  div_req_t         div_req_q;
  div_rsp_t         div_rsp;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  tsam_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  logic             in_acc;
  logic [VAL_W-1:0] reading;
  logic             irq_level;
  logic [ACC_W:0]   sum_x, sum_y;
  logic [ACC_W-1:0] sat_x, sat_y;
  logic             touch_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign reading   = s_axis_tdata[14:3];
  assign irq_level = s_axis_tdata[16];
  assign sum_x = {1'b0, x_acc_q} + (ACC_W + 1)'(reading);
  assign sum_y = {1'b0, y_acc_q} + (ACC_W + 1)'(reading);
  assign sat_x = (sum_x > ACC_LIMIT) ? ACC_LIMIT[ACC_W-1:0] : sum_x[ACC_W-1:0];
  assign sat_y = (sum_y > ACC_LIMIT) ? ACC_LIMIT[ACC_W-1:0] : sum_y[ACC_W-1:0];

  always_comb begin
    if (irq_en_q) begin
      touch_d = !irq_level;
    end else if (was_touched_q) begin
      touch_d = press_q > VAL_W'(RELEASE_LEVEL);
    end else begin
      touch_d = press_q >= VAL_W'(PRESS_LEVEL);
    end
  end

  // one axis average a cycle
  logic [ACC_W-1:0] acc_sel;
  logic [2*ACC_W:0] avg_prod;

  assign acc_sel  = axis_q ? y_acc_q : x_acc_q;
  assign avg_prod = (2*ACC_W+1)'(acc_sel) * (2*ACC_W+1)'(RECIP);

  // per-axis operand selection for the clamp stage
  logic [VAL_W-1:0] raw_sel, lo_sel, hi_sel, scr_sel, clamped;
  logic [DIV_W-1:0] product;

  assign raw_sel = axis_q ? avg_y_q : avg_x_q;
  assign lo_sel  = axis_q ? y_min_q : x_min_q;
  assign hi_sel  = axis_q ? y_max_q : x_max_q;
  assign scr_sel = axis_q ? scr_h_q : scr_w_q;
  assign clamped = (raw_sel < lo_sel) ? lo_sel : ((raw_sel > hi_sel) ? hi_sel : raw_sel);
  assign product = DIV_W'(diff_q) * DIV_W'(scrm1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      press_q       <= '0;
      x_acc_q       <= '0;
      y_acc_q       <= '0;
      cnt_q         <= '0;
      was_touched_q <= 1'b0;
      touch_q       <= 1'b0;
      axis_q        <= 1'b0;
      div_req_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (s_axis_tuser)
              CH_PRESSURE: begin
                press_q <= reading;
                x_acc_q <= '0;
                y_acc_q <= '0;
                cnt_q   <= '0;
              end
              CH_X: begin
                x_acc_q <= sat_x;
              end
              CH_Y: begin
                y_acc_q <= sat_y;
                if (cnt_q == CNT_W'(SAMPLES - 1)) begin
                  touch_q         <= touch_d;
                  was_touched_q   <= touch_d;
                  axis_q          <= 1'b0;
                  state_q         <= ST_AVG_RUN;
                end else begin
                  cnt_q <= cnt_q + CNT_W'(1);
                end
              end
              default: ;
            endcase
          end
        end
        ST_AVG_RUN: begin
          if (!axis_q) begin
            axis_q <= 1'b1;
          end else begin
            axis_q  <= 1'b0;
            state_q <= touch_q ? ST_CLAMP : ST_EMIT;
          end
        end
        ST_CLAMP: begin
          state_q <= ST_MULT;
        end
        ST_MULT: begin
          div_req_q.start    <= 1'b1;
          div_req_q.dividend <= product;
          div_req_q.divisor  <= span_q;
          div_req_q.steps    <= STEP_W'(DIV_W);
          state_q            <= ST_MAP_RUN;
        end
        ST_MAP_RUN: begin
          if (div_rsp.done) begin
            axis_q  <= 1'b1;
            state_q <= axis_q ? ST_EMIT : ST_CLAMP;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            x_acc_q     <= '0;
            y_acc_q     <= '0;
            cnt_q       <= '0;
            axis_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        pos_x_q <= '0;
        pos_y_q <= '0;
      end
      ST_AVG_RUN: begin
        if (axis_q) begin
          avg_y_q <= avg_prod[REC_SH +: VAL_W];
        end else begin
          avg_x_q <= avg_prod[REC_SH +: VAL_W];
        end
      end
      ST_CLAMP: begin
        diff_q  <= clamped - lo_sel;
        span_q  <= hi_sel - lo_sel;
        scrm1_q <= scr_sel - VAL_W'(1);
        // empty window or zero screen maps to 0
        zero_q  <= (hi_sel <= lo_sel) || (scr_sel == '0);
      end
      ST_MAP_RUN: begin
        if (div_rsp.done) begin
          if (axis_q) begin
            pos_y_q <= zero_q ? '0 : div_rsp.quotient;
          end else begin
            pos_x_q <= zero_q ? '0 : div_rsp.quotient;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= {3'b000, avg_y_q, avg_x_q, press_q, pos_y_q, pos_x_q, touch_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tsam_checker.sv
// tsam_checker: port-level assertions for touch_sample_average_and_map
// and the bind that attaches it
// depends on tsam_pkg
`default_nettype none

module tsam_checker
  import tsam_pkg::*;
(
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   s_axis_tvalid,
  input wire                   s_axis_tready,
  input wire [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire [IN_TUSER_W-1:0]  s_axis_tuser,
  input wire                   m_axis_tvalid,
  input wire                   m_axis_tready,
  input wire [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // only a scan end keeps the input busy
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != CH_Y) |=> s_axis_tready)
    else $error("input not ready after a non-Y request");

  // a new result is only loaded while the input side is busy
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a scan end");

  // positions are zero when no touch
  a_untouched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[24:1] == 24'd0))
    else $error("nonzero position without touch");

endmodule

bind touch_sample_average_and_map tsam_checker u_tsam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/touch_sample_average_and_map_chk.sv
// touch_sample_average_and_map_chk: watches both streams and the register port of the
// touch averaging block, predicts every scan result and compares it field by field
// depends on tsam_pkg
module touch_sample_average_and_map_chk
  import tsam_pkg::*;
#(
  parameter int SAMPLES       = 4,
  parameter int PRESS_LEVEL   = 20,
  parameter int RELEASE_LEVEL = 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  input  wire                   s_axis_tready,
  // [15:0] frame, [16] irq_level, [23:17] zero
  input  wire [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] channel
  input  wire [IN_TUSER_W-1:0]  s_axis_tuser,
  input  wire                   m_axis_tvalid,
  input  wire                   m_axis_tready,
  // [0] touched, [12:1] x_pos, [24:13] y_pos, [36:25] pressure,
  // [48:37] raw_x_avg, [60:49] raw_y_avg, [63:61] zero
  input  wire [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire                   cfg_we_i,
  input  wire [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i,
  output int                    fail_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    touches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SUM_CAP = SAMPLES * 4095;

  typedef struct packed {
    logic [2:0]       pad;
    logic [VAL_W-1:0] raw_y_avg;
    logic [VAL_W-1:0] raw_x_avg;
    logic [VAL_W-1:0] pressure;
    logic [VAL_W-1:0] y_pos;
    logic [VAL_W-1:0] x_pos;
    logic             touched;
  } scan_res_t;

  // calibration and scan state as the block should hold it
  logic             irq_en;
  logic [VAL_W-1:0] scr_w, scr_h, x_lo, x_hi, y_lo, y_hi;
  logic [VAL_W-1:0] held_press;
  int unsigned      x_sum, y_sum, y_seen;
  logic             prev_touch;

  scan_res_t expected_scans[$];
  int n_fail   = 0;
  int n_pushed = 0;
  int n_seen   = 0;
  int n_touch  = 0;

  assign fail_o    = n_fail;
  assign pending_o = n_pushed - n_seen;
  assign results_o = n_seen;
  assign touches_o = n_touch;

  function automatic int unsigned add_sat(int unsigned acc, int unsigned v);
    int unsigned s;
    s = acc + v;
    return (s > SUM_CAP) ? SUM_CAP : s;
  endfunction

  function automatic logic [VAL_W-1:0] map_axis(int unsigned raw, int unsigned lo,
                                                int unsigned hi, int unsigned span);
    if (hi <= lo || span == 0) return '0;
    if (raw < lo) raw = lo;
    if (raw > hi) raw = hi;
    return VAL_W'(((raw - lo) * (span - 1)) / (hi - lo));
  endfunction

  task automatic absorb_conversion(input logic [IN_TUSER_W-1:0] kind,
                                   input logic [15:0] frame, input logic irq_pin);
    logic [VAL_W-1:0] rd;
    int unsigned      ax, ay;
    logic             hit;
    scan_res_t        r;
    rd = frame[14:3];
    case (kind)
      CH_PRESSURE: begin
        held_press = rd;
        x_sum      = 0;
        y_sum      = 0;
        y_seen     = 0;
      end
      CH_X: x_sum = add_sat(x_sum, 32'(rd));
      CH_Y: begin
        y_sum = add_sat(y_sum, 32'(rd));
        y_seen++;
        if (y_seen >= SAMPLES) begin
          ax = x_sum / SAMPLES;
          ay = y_sum / SAMPLES;
          // pen pin when enabled, else hysteresis on the previous decision
          if (irq_en) hit = !irq_pin;
          else if (prev_touch) hit = held_press > RELEASE_LEVEL;
          else hit = held_press >= PRESS_LEVEL;
          prev_touch = hit;
          r           = '0;
          r.touched   = hit;
          r.x_pos     = hit ? map_axis(ax, 32'(x_lo), 32'(x_hi), 32'(scr_w)) : '0;
          r.y_pos     = hit ? map_axis(ay, 32'(y_lo), 32'(y_hi), 32'(scr_h)) : '0;
          r.pressure  = held_press;
          r.raw_x_avg = ax[VAL_W-1:0];
          r.raw_y_avg = ay[VAL_W-1:0];
          expected_scans.push_back(r);
          n_pushed++;
          x_sum  = 0;
          y_sum  = 0;
          y_seen = 0;
        end
      end
      // unused channel: no effect
      default: ;
    endcase
  endtask

  task automatic compare_scan(input scan_res_t got);
    scan_res_t want;
    n_seen++;
    if (got.touched === 1'b1) n_touch++;
    if (expected_scans.size() == 0) begin
      n_fail++;
      if (n_fail <= 10) $display("result request with none expected: %h", got);
      return;
    end
    want = expected_scans.pop_front();
    if (got.touched !== want.touched || got.x_pos !== want.x_pos ||
        got.y_pos !== want.y_pos || got.pressure !== want.pressure ||
        got.raw_x_avg !== want.raw_x_avg || got.raw_y_avg !== want.raw_y_avg) begin
      n_fail++;
      if (n_fail <= 10) begin
        $display("scan %0d expected: touched=%0d x=%0d y=%0d p=%0d avg_x=%0d avg_y=%0d",
                 n_seen, want.touched, want.x_pos, want.y_pos, want.pressure,
                 want.raw_x_avg, want.raw_y_avg);
        $display("scan %0d actual:   touched=%0d x=%0d y=%0d p=%0d avg_x=%0d avg_y=%0d",
                 n_seen, got.touched, got.x_pos, got.y_pos, got.pressure,
                 got.raw_x_avg, got.raw_y_avg);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // default calibration: 320x480 screen, X 220..3850, Y 260..3820
      irq_en     = 1'b0;
      scr_w      = 12'd320;
      scr_h      = 12'd480;
      x_lo       = 12'd220;
      x_hi       = 12'd3850;
      y_lo       = 12'd260;
      y_hi       = 12'd3820;
      held_press = '0;
      x_sum      = 0;
      y_sum      = 0;
      y_seen     = 0;
      prev_touch = 1'b0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (cfg_addr_i)
          REG_IRQ_ENABLE:    irq_en = cfg_data_i[0];
          REG_SCREEN_WIDTH:  scr_w  = cfg_data_i;
          REG_SCREEN_HEIGHT: scr_h  = cfg_data_i;
          REG_X_RAW_MIN:     x_lo   = cfg_data_i;
          REG_X_RAW_MAX:     x_hi   = cfg_data_i;
          REG_Y_RAW_MIN:     y_lo   = cfg_data_i;
          REG_Y_RAW_MAX:     y_hi   = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) compare_scan(m_axis_tdata);
      if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
        absorb_conversion(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16]);
    end
  end

endmodule

FILE: tb/tb.sv
// tb: clock, reset and stimulus for touch_sample_average_and_map; sends converter
// scans under several calibrations with random gaps and back-pressure
// depends on tsam_pkg, the block and touch_sample_average_and_map_chk
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsam_pkg::*;

  localparam int SAMPLES         = 4;
  localparam int PRESS_LEVEL     = 20;
  localparam int RELEASE_LEVEL   = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int N_CALS          = 7;
  // well beyond the scan end path
  localparam int SETTLE_CYCLES   = 150;
  localparam int LIMIT_CYCLES    = 500_000;
  localparam logic [IN_TUSER_W-1:0] CH_UNUSED = 2'd3;

  typedef struct packed {
    logic             irq;
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] h;
    logic [VAL_W-1:0] xl;
    logic [VAL_W-1:0] xh;
    logic [VAL_W-1:0] yl;
    logic [VAL_W-1:0] yh;
  } cal_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  int chk_fails, chk_pending, chk_results, chk_touches;

  logic in_took  = 1'b0;
  logic out_took = 1'b0;
  bit   tx_calm  = 1'b0;
  bit   rx_calm  = 1'b0;
  int   rx_hold  = 0;
  int   n_items   = 0;
  int   n_ignored = 0;
  int   n_cycles  = 0;
  cal_t cals[N_CALS];

  touch_sample_average_and_map #(
    .SAMPLES      (SAMPLES),
    .PRESS_LEVEL  (PRESS_LEVEL),
    .RELEASE_LEVEL(RELEASE_LEVEL)
  ) u_top (.*);

  touch_sample_average_and_map_chk #(
    .SAMPLES      (SAMPLES),
    .PRESS_LEVEL  (PRESS_LEVEL),
    .RELEASE_LEVEL(RELEASE_LEVEL)
  ) u_chk (
    .fail_o   (chk_fails),
    .pending_o(chk_pending),
    .results_o(chk_results),
    .touches_o(chk_touches),
    .*
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    in_took  <= (s_axis_tvalid && s_axis_tready) === 1'b1;
    out_took <= (m_axis_tvalid && m_axis_tready) === 1'b1;
  end

  // receiver: random stall before each result request, with calm stretches
  always @(negedge clk_i) begin
    if (out_took) begin
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
    end
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic cal_t mk_cal(logic irq, int w, int h, int xl, int xh, int yl, int yh);
    cal_t c;
    c.irq = irq;
    c.w   = VAL_W'(w);
    c.h   = VAL_W'(h);
    c.xl  = VAL_W'(xl);
    c.xh  = VAL_W'(xh);
    c.yl  = VAL_W'(yl);
    c.yh  = VAL_W'(yh);
    return c;
  endfunction

  // reading lands in bits 14..3, the rest of the frame is random
  function automatic logic [15:0] frame_of(int rd);
    logic [15:0] f;
    f       = 16'($urandom);
    f[14:3] = rd[11:0];
    return f;
  endfunction

  function automatic int near(int c);
    int v;
    v = c + $urandom_range(0, 32) - 16;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // called and returns at a falling edge; valid stays high into the next request
  task automatic push_item(input logic [IN_TUSER_W-1:0] kind, input logic [15:0] frame,
                           input logic irq);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-17){1'b0}}, irq, frame};
    s_axis_tuser  <= kind;
    do @(negedge clk_i); while (!in_took);
    if (kind == CH_UNUSED) n_ignored++;
    else n_items++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  task automatic write_cal(input cal_t c);
    write_reg(REG_IRQ_ENABLE, {{(CFG_DATA_W-1){1'b0}}, c.irq});
    write_reg(REG_SCREEN_WIDTH, c.w);
    write_reg(REG_SCREEN_HEIGHT, c.h);
    write_reg(REG_X_RAW_MIN, c.xl);
    write_reg(REG_X_RAW_MAX, c.xh);
    write_reg(REG_Y_RAW_MIN, c.yl);
    write_reg(REG_Y_RAW_MAX, c.yh);
    cfg_we_i <= 1'b0;
  endtask

  // let every expected result drain and the divider go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // pressure frame, X and Y samples in random order, final Y last
  task automatic random_scan();
    int press, cx, cy, xs_left, ys_left;
    case ($urandom_range(0, 15))
      0: press = 0;
      1: press = RELEASE_LEVEL - 1;
      2: press = RELEASE_LEVEL;
      3: press = RELEASE_LEVEL + 1;
      4: press = PRESS_LEVEL - 1;
      5: press = PRESS_LEVEL;
      6: press = PRESS_LEVEL + 1;
      7: press = 4095;
      default: press = $urandom_range(0, 4095);
    endcase
    cx      = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 4095);
    cy      = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 4095);
    xs_left = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * SAMPLES) : SAMPLES;
    ys_left = SAMPLES - 1;
    push_item(CH_PRESSURE, frame_of(press), 1'($urandom_range(0, 1)));
    while (xs_left + ys_left > 0) begin
      if ($urandom_range(0, 24) == 0)
        push_item(CH_UNUSED, 16'($urandom), 1'($urandom_range(0, 1)));
      if (ys_left == 0 || (xs_left > 0 && $urandom_range(0, 1) == 1)) begin
        push_item(CH_X, frame_of(near(cx)), 1'($urandom_range(0, 1)));
        xs_left--;
      end else begin
        push_item(CH_Y, frame_of(near(cy)), 1'($urandom_range(0, 1)));
        ys_left--;
      end
    end
    push_item(CH_Y, frame_of(near(cy)), 1'($urandom_range(0, 1)));
  endtask

  // stray requests of any kind, breaking scans apart
  task automatic noise_burst();
    int n;
    n = $urandom_range(1, 6);
    repeat (n)
      push_item(IN_TUSER_W'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int goal;
    cals[0] = mk_cal(1'b1, 320, 480, 220, 3850, 260, 3820);
    cals[1] = mk_cal(1'b0, 4095, 4095, 0, 4095, 0, 4095);
    cals[2] = mk_cal(1'b1, 0, 1, 0, 4095, 100, 3000);
    // empty X window, inverted Y window
    cals[3] = mk_cal(1'b0, 800, 600, 2000, 2000, 3000, 1000);
    cals[4] = mk_cal(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095));
    cals[5] = mk_cal(1'b0, 1, 0, 2047, 2048, 4094, 4095);
    cals[6] = mk_cal(1'($urandom_range(0, 1)), $urandom_range(1, 4095),
                     $urandom_range(1, 4095),
                     $urandom_range(0, 2000), $urandom_range(2001, 4095),
                     $urandom_range(0, 2000), $urandom_range(2001, 4095));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full-scale pressure and saturating X sums, zero Y, pen pin low at the end
    push_item(CH_PRESSURE, 16'hFFFF, 1'b1);
    repeat (SAMPLES + 1) push_item(CH_X, 16'hFFFF, 1'b0);
    repeat (SAMPLES - 1) push_item(CH_Y, 16'h0000, 1'b1);
    push_item(CH_Y, 16'h0007, 1'b0);
    push_item(CH_UNUSED, 16'hFFFF, 1'b1);
    // zero pressure after a touch releases; samples at the window edges
    push_item(CH_PRESSURE, 16'h8007, 1'b0);
    for (int i = 0; i < SAMPLES; i++) begin
      push_item(CH_X, {1'b0, 12'd220, 3'b000}, 1'b1);
      push_item(CH_Y, {1'b1, 12'd3820, 3'b101}, 1'b0);
    end
    // Y samples with no pressure frame reuse the held pressure
    for (int i = 0; i < SAMPLES; i++) push_item(CH_Y, {1'b0, 12'hAAA, 3'b010}, i[0]);

    for (int ph = 0; ph <= N_CALS; ph++) begin
      if (ph > 0) begin
        settle();
        write_cal(cals[ph-1]);
      end
      goal = n_items + ITEMS_PER_PHASE;
      while (n_items < goal) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) noise_burst();
        else random_scan();
      end
    end

    settle();
    $display("sent %0d conversions and %0d on the unused channel under %0d calibrations",
             n_items, n_ignored, N_CALS + 1);
    $display("compared %0d scan results, %0d touched, %0d mismatched",
             chk_results, chk_touches, chk_fails);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
